### rtl/erts_pkg.sv
// shared types and constants for the error rate threshold search
// no dependencies; used by every module under rtl
package erts_pkg;

	localparam int SCORE_W   = 32;
	localparam int CNT_W     = 17;
	localparam int TERM_W    = 34;
	localparam int COST_W    = 35;
	localparam int MAX_ITEMS = 65536;
	localparam int CFG_IDX_W = 2;
	localparam int MODE_W    = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_TOTAL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMPOSTOR_TOTAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_METRIC_MODE    = 2'd2;

	localparam logic [MODE_W-1:0] MODE_EER   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HTER  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic                      is_client;
		logic                      last;
	} item_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] threshold;
		logic [CNT_W-1:0]          false_accept_count;
		logic [CNT_W-1:0]          false_reject_count;
		logic                      total_error;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]  client_total;
		logic [CNT_W-1:0]  impostor_total;
		logic [MODE_W-1:0] metric_mode;
		logic [TERM_W-1:0] total_product;
	} cfg_t;

endpackage

### rtl/erts_cfg.sv
// configuration registers and the registered product of the two totals
// depends on erts_pkg
module erts_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [erts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [erts_pkg::CNT_W-1:0]     cfg_data,
	output erts_pkg::cfg_t                 cfg
);

	logic [erts_pkg::CNT_W-1:0]  client_total_q;
	logic [erts_pkg::CNT_W-1:0]  impostor_total_q;
	logic [erts_pkg::MODE_W-1:0] metric_mode_q;
	logic [erts_pkg::TERM_W-1:0] product_q;
	logic [erts_pkg::CNT_W-1:0]  client_total_d;
	logic [erts_pkg::CNT_W-1:0]  impostor_total_d;

	assign cfg_ready = 1'b1;

	// totals as they stand after this edge, so the product is current with them
	always_comb begin
		client_total_d   = client_total_q;
		impostor_total_d = impostor_total_q;
		if (cfg_valid) begin
			case (cfg_index)
				erts_pkg::CFG_CLIENT_TOTAL:   client_total_d   = cfg_data;
				erts_pkg::CFG_IMPOSTOR_TOTAL: impostor_total_d = cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_total_q   <= '0;
			impostor_total_q <= '0;
			metric_mode_q    <= erts_pkg::MODE_EER;
			product_q        <= '0;
		end else begin
			client_total_q   <= client_total_d;
			impostor_total_q <= impostor_total_d;
			product_q <= erts_pkg::TERM_W'(client_total_d) * erts_pkg::TERM_W'(impostor_total_d);
			if (cfg_valid) begin
				case (cfg_index)
					erts_pkg::CFG_METRIC_MODE: metric_mode_q <= cfg_data[erts_pkg::MODE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	assign cfg.client_total   = client_total_q;
	assign cfg.impostor_total = impostor_total_q;
	assign cfg.metric_mode    = metric_mode_q;
	assign cfg.total_product  = product_q;

endmodule

### rtl/erts_search.sv
// input register, running error terms and best-point search
// depends on erts_pkg
module erts_search (
	input  logic              clk,
	input  logic              arst_n,
	input  erts_pkg::cfg_t    cfg,
	input  logic              item_valid,
	output logic              item_stall,
	input  erts_pkg::item_t   item,
	input  logic              res_ready,
	output logic              res_load,
	output erts_pkg::result_t res_word
);

	localparam int CW = erts_pkg::COST_W;
	localparam int NW = erts_pkg::CNT_W;
	localparam int TW = erts_pkg::TERM_W;
	localparam int SW = erts_pkg::SCORE_W;

	function automatic logic [SW-1:0] floor_mid(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW:0] s;
		begin
			s = {a[SW-1], a} + {b[SW-1], b};
			return s[SW:1];
		end
	endfunction

	erts_pkg::item_t item_s1;
	logic            valid_s1;

	logic                 first_q;
	logic [NW-1:0]        imp_left_q;
	logic [NW-1:0]        cli_seen_q;
	logic signed [TW-1:0] imp_term_q;
	logic signed [CW-1:0] diff_q;
	logic signed [CW-1:0] ndiff_q;
	logic signed [CW-1:0] sum_q;
	logic [CW-1:0]        best_cost_q;
	logic [NW-1:0]        best_acc_q;
	logic [NW-1:0]        best_rej_q;
	logic [SW-1:0]        held_q;
	logic                 pend_q;

	logic                 adv;
	logic [NW-1:0]        b_imp_left, b_cli_seen, n_imp_left, n_cli_seen;
	logic signed [TW-1:0] b_imp_term, n_imp_term;
	logic signed [CW-1:0] b_diff, b_ndiff, b_sum, n_diff, n_ndiff, n_sum;
	logic signed [CW-1:0] c_ext, i_ext, prod_ext;
	logic [CW-1:0]        b_best, cost;
	logic [NW-1:0]        b_acc, b_rej, n_acc, n_rej;
	logic [SW-1:0]        b_held, mid_held, n_held;
	logic                 b_pend, cli_inc, imp_dec, better, err;
	logic [NW:0]          count_sum;

	assign adv        = valid_s1 && (!item_s1.last || res_ready);
	assign item_stall = valid_s1 && !adv;
	assign res_load   = adv && item_s1.last;

	assign c_ext    = $signed({{(CW-NW){1'b0}}, cfg.client_total});
	assign i_ext    = $signed({{(CW-NW){1'b0}}, cfg.impostor_total});
	assign prod_ext = $signed({{(CW-TW){1'b0}}, cfg.total_product});

	always_comb begin
		if (first_q) begin
			b_imp_left = cfg.impostor_total;
			b_cli_seen = '0;
			b_imp_term = $signed(cfg.total_product);
			b_diff     = prod_ext;
			b_ndiff    = -prod_ext;
			b_sum      = prod_ext;
			b_best     = '1;
			b_acc      = '0;
			b_rej      = '0;
			b_held     = '0;
			b_pend     = 1'b0;
		end else begin
			b_imp_left = imp_left_q;
			b_cli_seen = cli_seen_q;
			b_imp_term = imp_term_q;
			b_diff     = diff_q;
			b_ndiff    = ndiff_q;
			b_sum      = sum_q;
			b_best     = best_cost_q;
			b_acc      = best_acc_q;
			b_rej      = best_rej_q;
			b_held     = held_q;
			b_pend     = pend_q;
		end
	end

	assign mid_held = b_pend ? floor_mid(b_held, item_s1.score) : b_held;

	assign cli_inc = item_s1.is_client && (b_cli_seen < NW'(erts_pkg::MAX_ITEMS));
	assign imp_dec = !item_s1.is_client && (b_imp_left != '0);

	always_comb begin
		n_cli_seen = b_cli_seen + NW'(cli_inc);
		n_imp_left = b_imp_left - NW'(imp_dec);
		n_imp_term = imp_dec ? b_imp_term - TW'(c_ext) : b_imp_term;
		if (cli_inc) begin
			n_diff  = b_diff - i_ext;
			n_ndiff = b_ndiff + i_ext;
			n_sum   = b_sum + i_ext;
		end else if (imp_dec) begin
			n_diff  = b_diff - c_ext;
			n_ndiff = b_ndiff + c_ext;
			n_sum   = b_sum - c_ext;
		end else begin
			n_diff  = b_diff;
			n_ndiff = b_ndiff;
			n_sum   = b_sum;
		end
	end

	// negative cost stands for a wrapped, very large one: compare as unsigned
	assign count_sum = {1'b0, n_imp_left} + {1'b0, n_cli_seen};

	always_comb begin
		case (cfg.metric_mode)
			erts_pkg::MODE_EER:
				cost = (n_imp_term[TW-1] || !n_diff[CW-1]) ? n_diff : n_ndiff;
			erts_pkg::MODE_HTER:
				cost = n_sum;
			default:
				cost = CW'(count_sum);
		endcase
	end

	assign better = cost < b_best;
	assign n_acc  = better ? n_imp_left : b_acc;
	assign n_rej  = better ? n_cli_seen : b_rej;
	assign n_held = better ? item_s1.score : mid_held;

	always_comb begin
		case (cfg.metric_mode)
			erts_pkg::MODE_EER, erts_pkg::MODE_HTER:
				err = (cfg.client_total == '0) || (cfg.impostor_total == '0);
			default:
				err = (cfg.client_total == '0) && (cfg.impostor_total == '0);
		endcase
	end

	assign res_word.threshold          = n_held;
	assign res_word.false_accept_count = n_acc;
	assign res_word.false_reject_count = n_rej;
	assign res_word.total_error        = err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= 1'b1;
			imp_left_q  <= '0;
			cli_seen_q  <= '0;
			imp_term_q  <= '0;
			diff_q      <= '0;
			ndiff_q     <= '0;
			sum_q       <= '0;
			best_cost_q <= '1;
			best_acc_q  <= '0;
			best_rej_q  <= '0;
			held_q      <= '0;
			pend_q      <= 1'b0;
		end else if (adv) begin
			first_q     <= item_s1.last;
			imp_left_q  <= n_imp_left;
			cli_seen_q  <= n_cli_seen;
			imp_term_q  <= n_imp_term;
			diff_q      <= n_diff;
			ndiff_q     <= n_ndiff;
			sum_q       <= n_sum;
			best_cost_q <= better ? cost : b_best;
			best_acc_q  <= n_acc;
			best_rej_q  <= n_rej;
			held_q      <= n_held;
			pend_q      <= better && !item_s1.last;
		end
	end

`ifndef SYNTH
	a_clients_capped: assert property (@(posedge clk) disable iff (!arst_n)
		cli_seen_q <= NW'(erts_pkg::MAX_ITEMS))
		else $error("client count above limit");

	a_impostors_fall: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !first_q |=> imp_left_q <= $past(imp_left_q))
		else $error("impostor count rose inside a set");

	a_last_closes_set: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.last |=> first_q && !pend_q)
		else $error("set not closed after last word");

	a_best_never_rises: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !first_q |=> best_cost_q <= $past(best_cost_q))
		else $error("best cost rose inside a set");
`endif

endmodule

### rtl/erts_out.sv
// result register between the search logic and the result channel
// depends on erts_pkg
module erts_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_load,
	input  erts_pkg::result_t res_word,
	output logic              res_ready,
	output logic              result_valid,
	input  logic              result_stall,
	output erts_pkg::result_t result
);

	logic              valid_q;
	erts_pkg::result_t word_q;

	assign res_ready    = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			word_q <= res_word;
		end
	end

endmodule

### rtl/error_rate_threshold_search.sv
// top level of the error rate threshold search
// depends on erts_pkg, erts_cfg, erts_search, erts_out
//
// channel   signals                               direction  word
// item      item_valid, item_stall, item          in         score, is_client, last
// result    result_valid, result_stall, result    out        threshold and counts
// config    cfg_valid, cfg_ready, cfg_index/data  in         register write
//
// one item per cycle while item_stall is low; an item passes the input register,
// then the search logic into the result register
// the totals product is registered at the same edge as a config write
// arst_n clears all control state and starts a fresh set
// item_stall rises only while a last word waits for a stalled result register
module error_rate_threshold_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  erts_pkg::item_t                item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output erts_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [erts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [erts_pkg::CNT_W-1:0]     cfg_data
);

	erts_pkg::cfg_t    cfg;
	erts_pkg::result_t res_word;
	logic              res_load;
	logic              res_ready;

	erts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	erts_search u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_ready  (res_ready),
		.res_load   (res_load),
		.res_word   (res_word)
	);

	erts_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_load     (res_load),
		.res_word     (res_word),
		.res_ready    (res_ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### test/erts_check_pkg.sv
// scoreboard for the error rate threshold search testbench: tracks the search
// on every accepted word and checks each threshold result in order
// depends on erts_pkg
`timescale 1ns / 100ps

package erts_check_pkg;

	import erts_pkg::*;

	class threshold_tracker;

		logic [CNT_W-1:0]          cli_total;
		logic [CNT_W-1:0]          imp_total;
		logic [MODE_W-1:0]         metric;

		logic [CNT_W-1:0]          imp_left;
		logic [CNT_W-1:0]          cli_seen;
		logic [TERM_W-1:0]         imp_term;
		logic [TERM_W-1:0]         cli_term;
		logic [COST_W-1:0]         best_cost;
		logic [CNT_W-1:0]          best_fa;
		logic [CNT_W-1:0]          best_fr;
		logic signed [SCORE_W-1:0] held;
		bit                        mid_pending;
		bit                        fresh_set;

		result_t     pending_results[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned sets;

		function new();
			cli_total  = '0;
			imp_total  = '0;
			metric     = MODE_EER;
			restart_set();
			fresh_set  = 1'b1;
			mismatches = 0;
			checked    = 0;
			sets       = 0;
		endfunction

		function void restart_set();
			imp_left    = imp_total;
			cli_seen    = '0;
			imp_term    = TERM_W'(imp_total) * TERM_W'(cli_total);
			cli_term    = '0;
			best_cost   = '1;
			best_fa     = '0;
			best_fr     = '0;
			held        = '0;
			mid_pending = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
			case (idx)
				CFG_CLIENT_TOTAL:   cli_total = data;
				CFG_IMPOSTOR_TOTAL: imp_total = data;
				CFG_METRIC_MODE:    metric = data[MODE_W-1:0];
				default: ;
			endcase
		endfunction

		// floored midpoint on one extra bit of range
		function logic signed [SCORE_W-1:0] midpoint_floor(logic signed [SCORE_W-1:0] a,
				logic signed [SCORE_W-1:0] b);
			logic signed [SCORE_W:0] s;
			s = $signed({a[SCORE_W-1], a}) + $signed({b[SCORE_W-1], b});
			return s[SCORE_W:1];
		endfunction

		function void take_score(item_t w);
			logic [COST_W-1:0] cost;
			result_t           exp_word;
			if (fresh_set)
				restart_set();
			fresh_set = 1'b0;
			if (mid_pending) begin
				held = midpoint_floor(held, w.score);
				mid_pending = 1'b0;
			end
			if (w.is_client) begin
				if (cli_seen < MAX_ITEMS) begin
					cli_seen++;
					cli_term += TERM_W'(imp_total);
				end
			end else if (imp_left != 0) begin
				imp_left--;
				imp_term -= TERM_W'(cli_total);
			end
			case (metric)
				MODE_EER:  cost = (imp_term >= cli_term) ? COST_W'(imp_term - cli_term)
						: COST_W'(cli_term - imp_term);
				MODE_HTER: cost = COST_W'(imp_term) + COST_W'(cli_term);
				default:   cost = COST_W'(imp_left) + COST_W'(cli_seen);
			endcase
			if (cost < best_cost) begin
				best_cost   = cost;
				best_fa     = imp_left;
				best_fr     = cli_seen;
				held        = w.score;
				mid_pending = !w.last;
			end
			if (w.last) begin
				exp_word.threshold          = held;
				exp_word.false_accept_count = best_fa;
				exp_word.false_reject_count = best_fr;
				if (metric == MODE_EER || metric == MODE_HTER)
					exp_word.total_error = (cli_total == 0) || (imp_total == 0);
				else
					exp_word.total_error = (cli_total == 0) && (imp_total == 0);
				pending_results.push_back(exp_word);
				fresh_set   = 1'b1;
				mid_pending = 1'b0;
				sets++;
			end
		endfunction

		task report(string line);
			$display("%s", line);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result word with nothing expected: %h", got));
			end else begin
				want = pending_results.pop_front();
				if (got.threshold !== want.threshold)
					report($sformatf("result %0d threshold: expected %0d got %0d",
						checked, want.threshold, got.threshold));
				if (got.false_accept_count !== want.false_accept_count)
					report($sformatf("result %0d false accepts: expected %0d got %0d",
						checked, want.false_accept_count, got.false_accept_count));
				if (got.false_reject_count !== want.false_reject_count)
					report($sformatf("result %0d false rejects: expected %0d got %0d",
						checked, want.false_reject_count, got.false_reject_count));
				if (got.total_error !== want.total_error)
					report($sformatf("result %0d total error flag: expected %0d got %0d",
						checked, want.total_error, got.total_error));
				checked++;
			end
		endtask

		task check_drained();
			if (pending_results.size() != 0)
				report($sformatf("%0d expected results never arrived", pending_results.size()));
		endtask

	endclass

endpackage

### test/tb_error_rate_threshold_search.sv
// testbench for error_rate_threshold_search: directed and random score sets
// under several register settings, with random idling on both sides
// depends on erts_pkg, erts_check_pkg and the rtl
`timescale 1ns / 100ps

module tb_error_rate_threshold_search;

	import erts_pkg::*;
	import erts_check_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
	localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
	localparam int RANDOM_ITEMS   = 1500;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_t                item_word;
	logic                 result_valid;
	logic                 result_stall;
	result_t              result_word;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_data;

	threshold_tracker tracker;
	bit               calm = 1'b0;
	int               scores_sent = 0;
	int               settings = 0;
	int               quiet_cycles = 0;

	error_rate_threshold_search i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_word),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(negedge clk) begin
		result_stall <= !calm && ($urandom_range(0, 99) < 9);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_result(result_word);
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("tb_error_rate_threshold_search: errors");
			$finish;
		end
	end

	task automatic send_item(input logic signed [SCORE_W-1:0] s, input logic c,
			input logic l);
		item_t w;
		w.score     = s;
		w.is_client = c;
		w.last      = l;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 9) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item_word  <= w;
		do @(posedge clk); while (item_stall);
		tracker.take_score(w);
		scores_sent++;
	endtask

	// stop sending, let every result come back, then cover the pipeline
	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
	endtask

	task automatic load_setting(input int c, input int i, input logic [MODE_W-1:0] mode,
			input bit spare);
		logic [CNT_W-1:0] mode_word;
		mode_word = CNT_W'($urandom);
		mode_word[MODE_W-1:0] = mode;
		write_reg(CFG_CLIENT_TOTAL, CNT_W'(c));
		write_reg(CFG_IMPOSTOR_TOTAL, CNT_W'(i));
		write_reg(CFG_METRIC_MODE, mode_word);
		if (spare)
			write_reg(CFG_SPARE, CNT_W'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic random_set(input int n, input int n_clients, input bit ordered,
			input bit narrow);
		int signed vals[$];
		bit        marks[$];
		int        j;
		bit        t;
		for (int k = 0; k < n; k++) begin
			vals.push_back(narrow ? int'($urandom_range(0, 24)) - 12 : int'($urandom));
			marks.push_back(k < n_clients);
		end
		for (int k = n - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			t = marks[k];
			marks[k] = marks[j];
			marks[j] = t;
		end
		if (ordered)
			vals.sort();
		for (int k = 0; k < n; k++)
			send_item(vals[k], marks[k], k == n - 1);
	endtask

	initial begin
		int start;
		int c;
		int i;
		int n;
		int kind;
		bit narrow;
		tracker      = new();
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item_word    = '0;
		result_stall = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_CLIENT_TOTAL;
		cfg_data     = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset totals: zero totals flag, single word set, then a two-word set
		send_item(32'sh8000_0000, 1'b1, 1'b1);
		send_item(32'sh8000_0000, 1'b0, 1'b0);
		send_item(32'sh7fff_ffff, 1'b1, 1'b1);
		drain_results();
		load_setting(2, 2, MODE_EER, 1'b0);
		send_item(-32'sd7, 1'b0, 1'b0);
		send_item(-32'sd4, 1'b1, 1'b0);
		send_item(32'sd3, 1'b0, 1'b0);
		send_item(32'sd8, 1'b1, 1'b1);
		drain_results();
		load_setting(2, 2, MODE_HTER, 1'b0);
		send_item(32'sh8000_0000, 1'b1, 1'b0);
		send_item(32'sh8000_0001, 1'b0, 1'b0);
		send_item(32'sh7fff_fffe, 1'b1, 1'b0);
		send_item(32'sh7fff_ffff, 1'b0, 1'b1);
		drain_results();
		load_setting(1, 2, MODE_COUNT, 1'b0);
		send_item(32'sh8000_0000, 1'b0, 1'b0);
		send_item(32'sh7fff_ffff, 1'b1, 1'b0);
		send_item(32'sh7fff_ffff, 1'b0, 1'b1);
		drain_results();
		load_setting(2, 1, MODE_SPARE, 1'b1);
		send_item(-32'sd1, 1'b1, 1'b0);
		send_item(32'sd0, 1'b0, 1'b0);
		send_item(32'sd1, 1'b1, 1'b1);
		drain_results();
		// more impostors than configured
		load_setting(1, 1, MODE_EER, 1'b0);
		send_item(-32'sd9, 1'b0, 1'b0);
		send_item(-32'sd6, 1'b0, 1'b0);
		send_item(-32'sd3, 1'b0, 1'b0);
		send_item(32'sd2, 1'b1, 1'b1);
		drain_results();
		load_setting(2, 1, MODE_HTER, 1'b0);
		send_item(32'sd5, 1'b1, 1'b0);
		send_item(32'sd5, 1'b0, 1'b0);
		send_item(32'sd5, 1'b1, 1'b1);
		drain_results();

		start = scores_sent;
		while (scores_sent - start < RANDOM_ITEMS) begin
			calm = (scores_sent - start >= 600) && (scores_sent - start < 900);
			drain_results();
			if ($urandom_range(0, 11) == 0) begin
				c = $urandom_range(0, 1) ? MAX_ITEMS : $urandom_range(0, MAX_ITEMS);
				i = $urandom_range(0, 1) ? MAX_ITEMS : $urandom_range(0, MAX_ITEMS);
			end else begin
				c = $urandom_range(0, 24);
				i = $urandom_range(0, 24);
			end
			load_setting(c, i, 2'($urandom_range(0, 3)), $urandom_range(0, 7) == 0);
			repeat ($urandom_range(1, 3)) begin
				kind   = $urandom_range(0, 9);
				narrow = $urandom_range(0, 3) == 0;
				if (kind < 7 && c + i != 0 && c + i <= 64) begin
					random_set(c + i, c, 1'b1, narrow);
				end else begin
					n = $urandom_range(1, 40);
					random_set(n, $urandom_range(0, n), kind != 9, narrow);
				end
			end
		end
		calm = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		tracker.check_drained();
		$display("ran %0d scores in %0d sets under %0d register settings, %0d results checked",
			scores_sent, tracker.sets, settings, tracker.checked);
		if (tracker.mismatches == 0) begin
			$display("tb_error_rate_threshold_search: clean");
		end else begin
			$display("%0d mismatches", tracker.mismatches);
			$display("tb_error_rate_threshold_search: errors");
		end
		$finish;
	end

endmodule
